/* design/mbps_pkg.sv */
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants for the masked byte pattern search.
// ----------------------------------------------------------------------------
package mbps_pkg;

	localparam int BYTE_W          = 8;
	localparam int OFFSET_W        = 32;
	localparam int REG_BYTES       = 24;
	localparam int MAX_PATTERN_DEF = 24;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 64;
	localparam int LEN_REG_W       = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW    = 3'd0,
		REG_PATTERN_MID    = 3'd1,
		REG_PATTERN_HIGH   = 3'd2,
		REG_CARE_MASK      = 3'd3,
		REG_PATTERN_LENGTH = 3'd4
	} cfg_reg_t;

	// what one cell compares its byte against
	typedef struct packed {
		logic              used;
		logic              care;
		logic [BYTE_W-1:0] pat;
	} cmp_t;

endpackage

/* design/mbps_in_if.sv */
// ----------------------------------------------------------------------------
// mbps_in_if
// Byte stream channel: one data byte and an end-of-region flag per word.
// ----------------------------------------------------------------------------
interface mbps_in_if;
	logic                        valid;
	logic                        ready;
	logic [mbps_pkg::BYTE_W-1:0] data_byte;
	logic                        last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* design/mbps_out_if.sv */
// ----------------------------------------------------------------------------
// mbps_out_if
// Result channel: found flag and match start offset.
// ----------------------------------------------------------------------------
interface mbps_out_if;
	logic                          valid;
	logic                          ready;
	logic                          found;
	logic [mbps_pkg::OFFSET_W-1:0] match_offset;

	modport source (output valid, output found, output match_offset, input ready);
	modport sink   (input valid, input found, input match_offset, output ready);
endinterface

/* design/mbps_cfg_if.sv */
// ----------------------------------------------------------------------------
// mbps_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mbps_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [mbps_pkg::CFG_IDX_W-1:0]  index;
	logic [mbps_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/mbps_cell.sv */
// ----------------------------------------------------------------------------
// mbps_cell
// One window position: holds a byte, passes it on, and checks the byte
// arriving this cycle against its pattern byte.
// ----------------------------------------------------------------------------
module mbps_cell (
	input  logic                        clk,
	input  logic                        shift,
	input  logic [mbps_pkg::BYTE_W-1:0] byte_in,
	input  mbps_pkg::cmp_t              cmp,
	output logic [mbps_pkg::BYTE_W-1:0] byte_q,
	output logic                        ok
);

	// compare sees the window after this word's shift
	assign ok = !cmp.used || !cmp.care || (cmp.pat == byte_in);

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= byte_in;
		end
	end

endmodule

/* design/masked_byte_pattern_search.sv */
// A result word is registered and valid in the cycle after the byte word that causes it.
// Throughput: one byte word per cycle while ready is high; the whole window is compared in the
// accepting cycle by the row of cells, with one output register behind it.
// Input ready drops only while a result waits and the sink is not ready.
// Reset (arst_n low) clears count, match flag and output valid, and loads the
// register defaults (length 1, all else 0); no clearing pass is needed.
// ----------------------------------------------------------------------------
// masked_byte_pattern_search
// Finds the first occurrence of a wildcarded byte pattern in a byte region.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search #(
	parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mbps_in_if.sink    byte_stream,
	mbps_out_if.source result,
	mbps_cfg_if.sink   cfg
);

	localparam int LENW = $clog2(MAX_PATTERN + 1);
	localparam int PIW  = $clog2(mbps_pkg::REG_BYTES);

	logic [mbps_pkg::CFG_DATA_W-1:0] pattern_low_q;
	logic [mbps_pkg::CFG_DATA_W-1:0] pattern_mid_q;
	logic [mbps_pkg::CFG_DATA_W-1:0] pattern_high_q;
	logic [mbps_pkg::REG_BYTES-1:0]  care_mask_q;
	logic [mbps_pkg::LEN_REG_W-1:0]  pattern_length_q;

	logic [mbps_pkg::OFFSET_W-1:0] bytes_seen_q;
	logic                          match_done_q;
	logic                          out_valid_q;
	logic                          found_q;
	logic [mbps_pkg::OFFSET_W-1:0] offset_q;

	logic [mbps_pkg::BYTE_W-1:0]   pat_bytes [mbps_pkg::REG_BYTES];
	logic [LENW-1:0]               len_eff;
	logic [mbps_pkg::BYTE_W-1:0]   win [MAX_PATTERN+1];
	logic [MAX_PATTERN-1:0]        ok_vec;
	logic                          accept;
	logic [mbps_pkg::OFFSET_W-1:0] seen_next;
	logic                          hit;
	logic                          not_found;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_mid_q    <= '0;
			pattern_high_q   <= '0;
			care_mask_q      <= '0;
			pattern_length_q <= mbps_pkg::LEN_REG_W'(1);
		end else if (cfg.valid) begin
			case (mbps_pkg::cfg_reg_t'(cfg.index))
				mbps_pkg::REG_PATTERN_LOW: begin
					pattern_low_q <= cfg.data;
				end
				mbps_pkg::REG_PATTERN_MID: begin
					pattern_mid_q <= cfg.data;
				end
				mbps_pkg::REG_PATTERN_HIGH: begin
					pattern_high_q <= cfg.data;
				end
				mbps_pkg::REG_CARE_MASK: begin
					care_mask_q <= cfg.data[mbps_pkg::REG_BYTES-1:0];
				end
				mbps_pkg::REG_PATTERN_LENGTH: begin
					pattern_length_q <= cfg.data[mbps_pkg::LEN_REG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		for (int j = 0; j < 8; j++) begin
			pat_bytes[j]      = pattern_low_q[j*8 +: 8];
			pat_bytes[j + 8]  = pattern_mid_q[j*8 +: 8];
			pat_bytes[j + 16] = pattern_high_q[j*8 +: 8];
		end
	end

	// length 0 acts as 1, anything above the window acts as the window
	always_comb begin
		if (pattern_length_q == '0) begin
			len_eff = LENW'(1);
		end else if (int'(pattern_length_q) > MAX_PATTERN) begin
			len_eff = LENW'(MAX_PATTERN);
		end else begin
			len_eff = LENW'(pattern_length_q);
		end
	end

	assign accept = byte_stream.valid && byte_stream.ready;
	assign win[0] = byte_stream.data_byte;

	// cell k checks the byte k places back; it lines up with pattern byte len-1-k
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		mbps_pkg::cmp_t cmp;

		always_comb begin
			int rel;
			rel      = int'(len_eff) - 1 - k;
			cmp.used = (rel >= 0);
			cmp.care = 1'b0;
			cmp.pat  = '0;
			if (rel >= 0 && rel < mbps_pkg::REG_BYTES) begin
				cmp.care = care_mask_q[PIW'(rel)];
				cmp.pat  = pat_bytes[PIW'(rel)];
			end
		end

		mbps_cell u_cell (
			.clk     (clk),
			.shift   (accept),
			.byte_in (win[k]),
			.cmp     (cmp),
			.byte_q  (win[k+1]),
			.ok      (ok_vec[k])
		);
	end

	assign seen_next = (bytes_seen_q == '1) ? bytes_seen_q : bytes_seen_q + 1'b1;
	assign hit       = !match_done_q && (seen_next >= mbps_pkg::OFFSET_W'(len_eff)) && (&ok_vec);
	assign not_found = byte_stream.last_byte && !match_done_q && !hit;

	assign byte_stream.ready = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q <= '0;
			match_done_q <= 1'b0;
		end else if (accept) begin
			if (byte_stream.last_byte) begin
				bytes_seen_q <= '0;
				match_done_q <= 1'b0;
			end else begin
				bytes_seen_q <= seen_next;
				match_done_q <= match_done_q || hit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && (hit || not_found)) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (hit || not_found)) begin
			found_q  <= hit;
			offset_q <= hit ? (seen_next - mbps_pkg::OFFSET_W'(len_eff)) : '0;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.found        = found_q;
	assign result.match_offset = offset_q;

endmodule

/* design/mbps_chk.sv */
// ----------------------------------------------------------------------------
// mbps_chk
// Port-level checks for the masked byte pattern search.
// ----------------------------------------------------------------------------
module mbps_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          found,
	input logic [mbps_pkg::OFFSET_W-1:0] match_offset
);

	// a result word only follows an accepted byte word
	a_result_after_byte: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result word without a preceding byte word");

	// not-found words carry a zero offset
	a_nf_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (match_offset == '0))
		else $error("not-found word with non-zero offset");

	// byte side stalls only while a result is held up
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("byte stream stalled without a blocked result");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(found) && $stable(match_offset)))
		else $error("result word changed while stalled");

endmodule

bind masked_byte_pattern_search mbps_chk u_mbps_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (byte_stream.valid),
	.in_ready     (byte_stream.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.found        (result.found),
	.match_offset (result.match_offset)
);
